### sv/suksi_pkg.sv
// Shared types and constants for the sorted unique key set.
// No dependencies; imported by every module of the block.
`default_nettype none

package suksi_pkg;

   localparam int KEY_W        = 64;
   localparam int ADDR_W       = 63;
   localparam int FLAG_POS     = 63;
   localparam int STATUS_W     = 3;
   localparam int ENTRY_CNT_W  = 5;
   localparam int CAPACITY_DEF = 16;

   // request actions
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

   typedef logic [KEY_W-1:0] key_type;

   // what a cell hands to its upper neighbor
   typedef struct packed {
      key_type key;
      logic    less;
   } cell_link_type;

endpackage

`default_nettype wire

### sv/suksi_cell.sv
// One storage cell of the sorted key chain: holds a key, compares it to the
// broadcast key and takes the new key or its lower neighbor's key on insert.
// Depends on suksi_pkg.
`default_nettype none

module suksi_cell
   import suksi_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          shift_en,
   input  wire logic          occupied,
   input  wire key_type       ins_key,
   input  wire cell_link_type prev_link,
   output cell_link_type      link,
   output logic              match
);

   key_type key_ff;
   key_type key_in;
   logic    less;

   assign less  = occupied && (key_ff < ins_key);
   assign match = occupied && (key_ff == ins_key);

   assign link.key  = key_ff;
   assign link.less = less;

   always_comb begin
      key_in = key_ff;
      if (!less) begin
         // first cell above the smaller keys takes the new key, the rest move up
         key_in = prev_link.less ? ins_key : prev_link.key;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         key_ff <= key_in;
      end
   end

endmodule

`default_nettype wire

### sv/sorted_unique_key_set_insert.sv
// Top level of the sorted unique key set: a row of compare-and-shift cells,
// the entry counter and the result register. Depends on suksi_pkg, suksi_cell.
//
//   channel | direction | beat contents
//   req_    | in        | action, code_address, private_flag
//   rsp_    | out       | status, entry_count
//
// One beat is taken per cycle while no result beat is stalled; every cell compares against the incoming key
// in parallel and shifts in the same cycle that the beat is taken.
// The result is registered and appears the cycle after its request beat.
// The request side stalls only while a result waits and rsp_ready is low.
// Reset empties the set by clearing the count; no sweep of the key cells.
`default_nettype none

module sorted_unique_key_set_insert
   import suksi_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_action,
   input  wire logic [ADDR_W-1:0]      req_code_address,
   input  wire logic                   req_private_flag,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [ENTRY_CNT_W-1:0]      rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = CNT_W + ENTRY_CNT_W;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [ENTRY_CNT_W-1:0] entry_ff, entry_in;
   logic [EXT_W-1:0]       count_ext;

   logic                   accept;
   logic                   shift_en;
   key_type                ins_key;
   logic [CAPACITY-1:0]    match_vec;
   cell_link_type          links [CAPACITY+1];

   assign accept  = req_valid && req_ready;
   assign ins_key = {req_private_flag, req_code_address};

   // bottom of the chain: everything below cell 0 counts as smaller
   assign links[0].key  = '0;
   assign links[0].less = 1'b1;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      suksi_cell u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .occupied  (CNT_W'(i) < count_ff),
         .ins_key   (ins_key),
         .prev_link (links[i]),
         .link      (links[i+1]),
         .match     (match_vec[i])
      );
   end

   always_comb begin
      shift_en  = 1'b0;
      count_in  = count_ff;
      status_in = ST_INSERTED;
      if (req_action == ACT_CLEAR) begin
         status_in = ST_CLEARED;
         count_in  = '0;
      end else if (req_code_address == '0) begin
         status_in = ST_ZERO;
      end else if (|match_vec) begin
         status_in = ST_DUPLICATE;
      end else if (count_ff == CNT_W'(CAPACITY)) begin
         status_in = ST_FULL;
      end else begin
         shift_en = accept;
         count_in = count_ff + CNT_W'(1);
      end
      count_ext = EXT_W'(count_in);
      entry_in  = count_ext[ENTRY_CNT_W-1:0];
   end

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         entry_ff  <= entry_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = entry_ff;

endmodule

`default_nettype wire

### sv/suksi_checker.sv
// Port-level checks for the sorted unique key set, bound to the top level.
// Depends on suksi_pkg and sorted_unique_key_set_insert.
`default_nettype none

module suksi_checker
   import suksi_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   req_action,
   input wire logic [ADDR_W-1:0]      req_code_address,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [STATUS_W-1:0]    rsp_status,
   input wire logic [ENTRY_CNT_W-1:0] rsp_entry_count
);

   localparam int EXT_W = 32 + ENTRY_CNT_W;
   localparam logic [EXT_W-1:0] CAP_EXT = EXT_W'(CAPACITY);
   localparam logic [ENTRY_CNT_W-1:0] CAP_CNT = CAP_EXT[ENTRY_CNT_W-1:0];

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count))
      else $error("result beat changed while stalled");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_CLEAR |=>
         rsp_valid && rsp_status == ST_CLEARED && rsp_entry_count == '0)
      else $error("clear did not report an empty set");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_INSERT && req_code_address == '0
         |=> rsp_valid && rsp_status == ST_ZERO)
      else $error("zero address not rejected");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == CAP_CNT)
      else $error("full reported with a count below capacity");

   // first cycle out of reset shows no result beat
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sorted_unique_key_set_insert suksi_checker #(.CAPACITY(CAPACITY)) u_suksi_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// Testbench for sorted_unique_key_set_insert: directed and random insert/clear beats
// checked against a behavioral copy of the sorted key set kept in the bench.
// Depends on suksi_pkg and the block's RTL.
module tb_top;
   import suksi_pkg::*;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] addr;
      logic              flag;
   } req_beat_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [ENTRY_CNT_W-1:0] count;
   } outcome_type;

   localparam int RANDOM_BEATS = 1400;
   localparam int CALM_TAIL    = 150;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_action = ACT_INSERT;
   logic [ADDR_W-1:0]      req_code_address = '0;
   logic                   req_private_flag = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [ENTRY_CNT_W-1:0] rsp_entry_count;

   key_type      set_keys [CAPACITY_DEF];
   int unsigned  set_size = 0;
   req_beat_type req_beats [$];
   outcome_type  outcome_q [$];
   bit           req_taken = 1'b0;
   bit           stim_done = 1'b0;
   int unsigned  req_gap = 0;
   int unsigned  rsp_gap = 0;
   int unsigned  mismatches = 0;
   int unsigned  random_beats = 0;

   sorted_unique_key_set_insert #(
      .CAPACITY(CAPACITY_DEF)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_code_address (req_code_address),
      .req_private_flag (req_private_flag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count)
   );

   always #5 clock = ~clock;

   // Apply one beat to the bench copy of the set and return its result.
   function automatic outcome_type update_key_set(req_beat_type b);
      key_type     key;
      int unsigned pos;
      outcome_type o;
      key = {b.flag, b.addr};
      if (b.action == ACT_CLEAR) begin
         set_size = 0;
         o.status = ST_CLEARED;
      end else if (b.addr == '0) begin
         o.status = ST_ZERO;
      end else begin
         pos = 0;
         while (pos < set_size && set_keys[pos] < key) pos++;
         if (pos < set_size && set_keys[pos] == key) begin
            o.status = ST_DUPLICATE;
         end else if (set_size >= CAPACITY_DEF) begin
            o.status = ST_FULL;
         end else begin
            for (int i = set_size; i > int'(pos); i--) set_keys[i] = set_keys[i-1];
            set_keys[pos] = key;
            set_size++;
            o.status = ST_INSERTED;
         end
      end
      o.count = ENTRY_CNT_W'(set_size);
      return o;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'({$urandom, $urandom});
   endfunction

   task automatic queue_beat(logic act, logic [ADDR_W-1:0] addr, logic flag);
      req_beats.push_back({act, addr, flag});
   endtask

   task automatic wait_for_idle();
      do @(posedge clock);
      while (req_beats.size() != 0 || req_valid || outcome_q.size() != 0);
   endtask

   // Driver: new beats and ready changes go out on the falling edge.
   always @(negedge clock) begin
      req_beat_type nxt;
      logic         drive;
      logic         rdy;
      bit           calm;
      calm  = stim_done && req_beats.size() < CALM_TAIL;
      drive = req_valid;
      nxt   = {req_action, req_code_address, req_private_flag};
      rdy   = 1'b0;
      if (!reset) begin
         // hold a beat until it is taken
         if (!req_valid || req_taken) begin
            drive = 1'b0;
            if (req_gap != 0) begin
               req_gap--;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               req_gap = $urandom_range(0, 12);
            end else if (req_beats.size() != 0) begin
               nxt   = req_beats.pop_front();
               drive = 1'b1;
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap--;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 12);
         end else begin
            rdy = 1'b1;
         end
      end
      req_valid        <= drive;
      req_action       <= nxt.action;
      req_code_address <= nxt.addr;
      req_private_flag <= nxt.flag;
      rsp_ready        <= rdy;
   end

   // Monitor: check result beats, then predict for the request beat taken at this edge.
   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (reset) begin
         req_taken = 1'b0;
         set_size  = 0;
      end else begin
         got = {rsp_status, rsp_entry_count};
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result beat: status %0d count %0d",
                           $time, got.status, got.count);
            end else begin
               want = outcome_q.pop_front();
               if (got.status !== want.status || got.count !== want.count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: status exp %0d got %0d, count exp %0d got %0d",
                              $time, want.status, got.status, want.count, got.count);
               end
            end
         end
         req_taken = req_valid && req_ready;
         if (req_taken)
            outcome_q.push_back(update_key_set({req_action, req_code_address,
                                                req_private_flag}));
      end
   end

   initial begin
      req_beat_type      issued [$];
      req_beat_type      b;
      int unsigned       len;
      int unsigned       pick;
      logic [ADDR_W-1:0] addr;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty clear, zero address, key extremes, duplicates, fill to full
      queue_beat(ACT_CLEAR, {ADDR_W{1'b1}}, 1'b1);
      queue_beat(ACT_INSERT, '0, 1'b0);
      queue_beat(ACT_INSERT, '0, 1'b1);
      queue_beat(ACT_INSERT, {ADDR_W{1'b1}}, 1'b1);
      queue_beat(ACT_INSERT, {ADDR_W{1'b1}}, 1'b0);
      queue_beat(ACT_INSERT, ADDR_W'(1), 1'b0);
      queue_beat(ACT_INSERT, ADDR_W'(1), 1'b1);
      queue_beat(ACT_INSERT, ADDR_W'(1), 1'b0);
      queue_beat(ACT_INSERT, {ADDR_W{1'b1}}, 1'b1);
      for (int k = 0; k < CAPACITY_DEF - 4; k++)
         queue_beat(ACT_INSERT, ADDR_W'(k * 37 + 100), 1'(k));
      queue_beat(ACT_INSERT, ADDR_W'(5000), 1'b0);
      queue_beat(ACT_INSERT, ADDR_W'(1), 1'b1);
      queue_beat(ACT_INSERT, '0, 1'b1);
      queue_beat(ACT_CLEAR, rand_addr(), 1'($urandom));

      // let the block drain before the random part starts
      wait_for_idle();

      while (random_beats < RANDOM_BEATS) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_beat(ACT_CLEAR, rand_addr(), 1'($urandom));
            issued.delete();
            random_beats++;
         end
         len = $urandom_range(1, 24);
         repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               queue_beat(ACT_INSERT, '0, 1'($urandom));
            end else if (pick < 7) begin
               queue_beat(ACT_CLEAR, rand_addr(), 1'($urandom));
               issued.delete();
            end else if (pick < 30 && issued.size() != 0) begin
               b = issued[$urandom_range(0, issued.size() - 1)];
               queue_beat(ACT_INSERT, b.addr, b.flag);
            end else if (pick < 38 && issued.size() != 0) begin
               // same address, other flag: a distinct key
               b = issued[$urandom_range(0, issued.size() - 1)];
               queue_beat(ACT_INSERT, b.addr, ~b.flag);
            end else begin
               case ($urandom_range(0, 3))
                  0: addr = ADDR_W'($urandom_range(1, 40));
                  1: addr = rand_addr();
                  2: addr = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 40));
                  default: addr = ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
               endcase
               b = {ACT_INSERT, addr, 1'($urandom)};
               issued.push_back(b);
               queue_beat(b.action, b.addr, b.flag);
            end
            random_beats++;
         end
      end
      stim_done = 1'b1;

      wait_for_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule

### filelist.f
sv/suksi_pkg.sv
sv/suksi_cell.sv
sv/sorted_unique_key_set_insert.sv
sv/suksi_checker.sv
tb/tb_top.sv
